// ===== rtl/core/lhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_pkg
// Types and constants shared by the handle cache and its checker.
// ----------------------------------------------------------------------------
package lhc_pkg;

   localparam int ENTRIES  = 8;
   localparam int AGE_BITS = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef logic [AGE_BITS-1:0] age_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [2:0]          slot_type;

   localparam age_type AGE_MAX = '1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] key;
      logic [31:0] handle;
   } lhc_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_handle;
      logic        evicted;
      logic [31:0] evicted_handle;
      slot_type    slot;
   } lhc_rsp_type;

   // operands of one entry step
   typedef struct packed {
      logic        is_insert;
      logic        first;
      logic [15:0] req_key;
      logic [15:0] entry_key;
      age_type     entry_age;
      age_type     best_age;
   } lhc_step_in_type;

   typedef struct packed {
      logic    match;
      logic    older;
      age_type new_age;
   } lhc_step_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_WRITE,
      ST_RESP
   } lhc_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/lhc_entry_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_entry_unit
// Shared compare and age unit: matches one entry's key, ranks its age
// against the oldest seen so far and produces its next age.
// ----------------------------------------------------------------------------
module lhc_entry_unit (
   input  wire lhc_pkg::lhc_step_in_type  step_in,
   output lhc_pkg::lhc_step_out_type      step_out
);

   lhc_pkg::age_type aged;

   always_comb begin
      // saturate at the top of the age range
      if (step_in.entry_age == lhc_pkg::AGE_MAX) begin
         aged = step_in.entry_age;
      end else begin
         aged = step_in.entry_age + lhc_pkg::age_type'(1);
      end

      step_out.match = (step_in.entry_key == step_in.req_key);
      // ties keep the earlier index
      step_out.older = step_in.first || (step_in.entry_age > step_in.best_age);

      if (!step_in.is_insert && step_out.match) begin
         step_out.new_age = '0;
      end else begin
         step_out.new_age = aged;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lru_handle_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_handle_cache
// Fully associative key-to-handle cache with least-recently-used
// replacement by saturating per-entry age counters.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  request   start, busy, req_data     taken when start & !busy
//  response  rsp_valid, rsp_data       one-cycle strobe, no back-pressure
//
//  A transaction passes through accept, a walk over the filled entries
//  one at a time through the shared compare/age unit (a full table holds 8),
//  a drain of the read register when the table is not empty, a table write
//  for an insert only, and the response strobe.
//  busy stays high from acceptance until the response strobe has gone.
//  Synchronous reset empties the table; entries are never cleared.
// ----------------------------------------------------------------------------
module lru_handle_cache (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire lhc_pkg::lhc_req_type  req_data,
   output logic                       rsp_valid,
   output lhc_pkg::lhc_rsp_type       rsp_data
);

   // table storage
   logic [15:0]      key_mem    [lhc_pkg::ENTRIES];
   logic [31:0]      handle_mem [lhc_pkg::ENTRIES];
   lhc_pkg::age_type age_mem    [lhc_pkg::ENTRIES];

   lhc_pkg::lhc_state_type state_ff, state_in;

   lhc_pkg::lhc_req_type req_ff;
   lhc_pkg::cnt_type     fill_ff;
   lhc_pkg::cnt_type     rd_ptr_ff;
   logic                 pipe_vld_ff;
   lhc_pkg::idx_type     pipe_idx_ff;
   logic [15:0]          key_rd_ff;
   logic [31:0]          handle_rd_ff;
   lhc_pkg::age_type     age_rd_ff;
   logic                 hit_ff;
   logic [31:0]          found_ff;
   lhc_pkg::idx_type     slot_ff;
   lhc_pkg::age_type     best_age_ff;
   lhc_pkg::idx_type     best_idx_ff;
   logic [31:0]          best_handle_ff;
   lhc_pkg::lhc_rsp_type rsp_ff;

   logic                 accept;
   logic                 issue;
   logic                 walk_done;
   logic                 is_insert;
   logic                 full;
   lhc_pkg::idx_type     rd_idx;
   lhc_pkg::idx_type     wr_idx;

   lhc_pkg::lhc_step_in_type  step_in;
   lhc_pkg::lhc_step_out_type step_out;

   lhc_entry_unit u_entry_unit (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign is_insert = (req_ff.req_type == lhc_pkg::REQ_INSERT);
   assign full      = (fill_ff == lhc_pkg::cnt_type'(lhc_pkg::ENTRIES));
   assign rd_idx    = rd_ptr_ff[lhc_pkg::IDX_W-1:0];
   assign wr_idx    = full ? best_idx_ff : fill_ff[lhc_pkg::IDX_W-1:0];

   always_comb begin
      step_in.is_insert = is_insert;
      step_in.first     = (pipe_idx_ff == '0);
      step_in.req_key   = req_ff.key;
      step_in.entry_key = key_rd_ff;
      step_in.entry_age = age_rd_ff;
      step_in.best_age  = best_age_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lhc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lhc_pkg::ST_WALK;
            end
         end
         lhc_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = is_insert ? lhc_pkg::ST_WRITE : lhc_pkg::ST_RESP;
            end
         end
         lhc_pkg::ST_WRITE: begin
            state_in = lhc_pkg::ST_RESP;
         end
         lhc_pkg::ST_RESP: begin
            state_in = lhc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lhc_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      busy      = (state_ff != lhc_pkg::ST_IDLE);
      rsp_valid = (state_ff == lhc_pkg::ST_RESP);
      accept    = (state_ff == lhc_pkg::ST_IDLE) && start;
      issue     = (state_ff == lhc_pkg::ST_WALK) && (rd_ptr_ff < fill_ff);
      walk_done = (state_ff == lhc_pkg::ST_WALK) && !issue && !pipe_vld_ff;
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lhc_pkg::ST_IDLE;
         fill_ff     <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= issue;
         if ((state_ff == lhc_pkg::ST_WRITE) && !full) begin
            fill_ff <= fill_ff + lhc_pkg::cnt_type'(1);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         rd_ptr_ff <= '0;
         hit_ff    <= 1'b0;
         found_ff  <= '0;
         slot_ff   <= '0;
      end

      // read stage: fetch one entry a cycle
      if (issue) begin
         rd_ptr_ff    <= rd_ptr_ff + lhc_pkg::cnt_type'(1);
         pipe_idx_ff  <= rd_idx;
         key_rd_ff    <= key_mem[rd_idx];
         handle_rd_ff <= handle_mem[rd_idx];
         age_rd_ff    <= age_mem[rd_idx];
      end

      // evaluate stage: update age, track hit and oldest entry
      if (pipe_vld_ff) begin
         age_mem[pipe_idx_ff] <= step_out.new_age;
         if (!is_insert && step_out.match) begin
            hit_ff   <= 1'b1;
            found_ff <= handle_rd_ff;
            slot_ff  <= pipe_idx_ff;
         end
         if (is_insert && step_out.older) begin
            best_age_ff    <= age_rd_ff;
            best_idx_ff    <= pipe_idx_ff;
            best_handle_ff <= handle_rd_ff;
         end
      end

      if (walk_done && !is_insert) begin
         rsp_ff.hit            <= hit_ff;
         rsp_ff.found_handle   <= found_ff;
         rsp_ff.evicted        <= 1'b0;
         rsp_ff.evicted_handle <= '0;
         rsp_ff.slot           <= lhc_pkg::slot_type'(slot_ff);
      end

      if (state_ff == lhc_pkg::ST_WRITE) begin
         key_mem[wr_idx]       <= req_ff.key;
         handle_mem[wr_idx]    <= req_ff.handle;
         age_mem[wr_idx]       <= '0;
         rsp_ff.hit            <= 1'b0;
         rsp_ff.found_handle   <= '0;
         rsp_ff.evicted        <= full;
         rsp_ff.evicted_handle <= full ? best_handle_ff : 32'd0;
         rsp_ff.slot           <= lhc_pkg::slot_type'(wr_idx);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/lhc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhc_checker
// Port-level checks on the handle cache's command and response timing and response flags.
// ----------------------------------------------------------------------------
module lhc_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        start,
   input wire                        busy,
   input wire                        rsp_valid,
   input wire lhc_pkg::lhc_rsp_type  rsp_data
);

   // a taken transaction holds the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transaction taken");

   // the response strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // the response closes the transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("busy not released after response");

   // a hit and an eviction never share one response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.hit && rsp_data.evicted))
      else $error("response flags both hit and eviction");

endmodule

bind lru_handle_cache lhc_checker u_lhc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/lru_handle_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_handle_cache_tb
// Self-checking bench for the LRU handle cache. A clocked driver presents
// lookups and inserts from a queue with random gaps, and a scoreboard keeps
// its own copy of the table (keys, handles, saturating ages) to predict each
// response. Every response strobe is checked field by field against the
// oldest prediction. The run starts with directed cases on an empty, a
// partly filled and a full table, then random traffic over a small key
// pool, so that hits, duplicate keys and evictions are frequent.
// ----------------------------------------------------------------------------
module lru_handle_cache_tb;

   localparam int RANDOM_ITEMS = 824;
   localparam int POOL_SIZE    = 12;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      lhc_pkg::lhc_req_type req;
      int unsigned          gap;
   } pending_req_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   lhc_pkg::lhc_req_type req_data  = '0;
   logic                 busy;
   logic                 rsp_valid;
   lhc_pkg::lhc_rsp_type rsp_data;

   // shadow copy of the cache
   logic [15:0]      tbl_key    [lhc_pkg::ENTRIES];
   logic [31:0]      tbl_handle [lhc_pkg::ENTRIES];
   lhc_pkg::age_type tbl_age    [lhc_pkg::ENTRIES];
   int               tbl_fill;

   pending_req_type      req_pending_q [$];
   pending_req_type      next_req;
   lhc_pkg::lhc_rsp_type rsp_expect_q [$];
   logic [15:0]          key_pool [POOL_SIZE];

   logic        in_flight = 1'b0;
   logic        req_taken = 1'b0;
   int unsigned gap_cnt   = 0;
   int          err_cnt   = 0;
   int          n_lookups = 0;
   int          n_hits    = 0;
   int          n_inserts = 0;
   int          n_evicts  = 0;
   int          n_checked = 0;

   lru_handle_cache dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic lhc_pkg::age_type aged(lhc_pkg::age_type a);
      return (a == lhc_pkg::AGE_MAX) ? a : a + 1'b1;
   endfunction

   // Apply one transaction to the shadow table and return its response.
   function automatic lhc_pkg::lhc_rsp_type cache_apply(lhc_pkg::lhc_req_type rq);
      lhc_pkg::lhc_rsp_type r;
      int                   victim;
      lhc_pkg::age_type     oldest;
      r = '0;
      if (rq.req_type == lhc_pkg::REQ_LOOKUP) begin
         for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_key[i] == rq.key) begin
               r.hit          = 1'b1;
               r.found_handle = tbl_handle[i];
               r.slot         = lhc_pkg::slot_type'(i);
               tbl_age[i]     = '0;
            end else begin
               tbl_age[i] = aged(tbl_age[i]);
            end
         end
      end else begin
         if (tbl_fill < lhc_pkg::ENTRIES) begin
            victim   = tbl_fill;
            tbl_fill = tbl_fill + 1;
         end else begin
            // oldest wins, lowest index on a tie
            victim = 0;
            oldest = tbl_age[0];
            for (int i = 1; i < lhc_pkg::ENTRIES; i++) begin
               if (tbl_age[i] > oldest) begin
                  victim = i;
                  oldest = tbl_age[i];
               end
            end
            r.evicted        = 1'b1;
            r.evicted_handle = tbl_handle[victim];
         end
         for (int i = 0; i < tbl_fill; i++)
            tbl_age[i] = aged(tbl_age[i]);
         tbl_key[victim]    = rq.key;
         tbl_handle[victim] = rq.handle;
         tbl_age[victim]    = '0;
         r.slot             = lhc_pkg::slot_type'(victim);
      end
      return r;
   endfunction

   task automatic queue_req(logic kind, logic [15:0] key, logic [31:0] handle,
                            int unsigned gap);
      pending_req_type p;
      p.req.req_type = kind;
      p.req.key      = key;
      p.req.handle   = handle;
      p.gap          = gap;
      req_pending_q.push_back(p);
   endtask

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         err_cnt++;
      end
   endtask

   // Driver: present the next request at the falling edge once its gap is used up.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            in_flight = 1'b0;
         end
         if (!in_flight) begin
            if (req_pending_q.size() != 0 && gap_cnt >= req_pending_q[0].gap) begin
               next_req = req_pending_q.pop_front();
               start    <= 1'b1;
               req_data <= next_req.req;
               in_flight = 1'b1;
               gap_cnt   = 0;
            end else begin
               if (req_pending_q.size() != 0)
                  gap_cnt++;
               start    <= 1'b0;
               // scramble the idle bus; the block must ignore it
               req_data <= lhc_pkg::lhc_req_type'(49'({$urandom, $urandom}));
            end
         end
      end
   end

   // Scoreboard: predict on acceptance, check on each response strobe.
   always @(posedge clock) begin
      if (reset) begin
         tbl_fill = 0;
         for (int i = 0; i < lhc_pkg::ENTRIES; i++) begin
            tbl_key[i]    = '0;
            tbl_handle[i] = '0;
            tbl_age[i]    = '0;
         end
      end else begin
         if (start && !busy && in_flight && !req_taken) begin
            rsp_expect_q.push_back(cache_apply(req_data));
            req_taken = 1'b1;
            if (req_data.req_type == lhc_pkg::REQ_LOOKUP) begin
               n_lookups++;
               n_hits += rsp_expect_q[$].hit;
            end else begin
               n_inserts++;
               n_evicts += rsp_expect_q[$].evicted;
            end
         end
         if (rsp_valid) begin
            if (rsp_expect_q.size() == 0) begin
               $error("response with no transaction outstanding");
               err_cnt++;
            end else begin
               check_field("hit", rsp_expect_q[0].hit, rsp_data.hit);
               check_field("found_handle", rsp_expect_q[0].found_handle,
                           rsp_data.found_handle);
               check_field("evicted", rsp_expect_q[0].evicted, rsp_data.evicted);
               check_field("evicted_handle", rsp_expect_q[0].evicted_handle,
                           rsp_data.evicted_handle);
               check_field("slot", rsp_expect_q[0].slot, rsp_data.slot);
               void'(rsp_expect_q.pop_front());
               n_checked++;
            end
         end
      end
   end

   initial begin
      int unsigned gap_hi;
      logic        kind;
      logic [15:0] key;

      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = 16'($urandom);

      // empty table, extreme keys and handles
      queue_req(lhc_pkg::REQ_LOOKUP, 16'h0000, 32'h0, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h8001, 32'h1234_5678, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_LOOKUP, 16'h0000, 32'h0, $urandom_range(0, 16));
      // hammer one key back to back so the other entries age past it
      for (int i = 0; i < 4; i++)
         queue_req(lhc_pkg::REQ_LOOKUP, 16'h8001, 32'h0, 0);
      queue_req(lhc_pkg::REQ_LOOKUP, 16'h1234, 32'h0, $urandom_range(0, 16));
      // duplicate key, then fill the table
      queue_req(lhc_pkg::REQ_INSERT, 16'hFFFF, 32'hA5A5_A5A5, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h5555, 32'h5555_5555, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'hAAAA, 32'hAAAA_AAAA, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h00FF, 32'h8000_0000, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'hFF00, 32'h0000_0001, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h7FFF, 32'h7FFF_FFFF, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_LOOKUP, 16'hFFFF, 32'h0, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'hC3C3, 32'hDEAD_BEEF, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'h3C3C, 32'h0F0F_0F0F, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_LOOKUP, 16'h0000, 32'h0, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_LOOKUP, 16'h3C3C, 32'h0, $urandom_range(0, 16));
      queue_req(lhc_pkg::REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 0);
      queue_req(lhc_pkg::REQ_LOOKUP, 16'hFFFF, 32'h0, 0);

      // random traffic in stretches of idle, light and no gaps
      gap_hi = 16;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0)
            case ($urandom_range(0, 2))
               0: gap_hi = 0;
               1: gap_hi = 2;
               default: gap_hi = 16;
            endcase
         kind = ($urandom_range(0, 99) < 45) ? lhc_pkg::REQ_INSERT : lhc_pkg::REQ_LOOKUP;
         if ($urandom_range(0, 99) < 75)
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else
            key = 16'($urandom);
         queue_req(kind, key, $urandom, $urandom_range(0, gap_hi));
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (req_pending_q.size() != 0 || in_flight)
         @(posedge clock);
      while (rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d lookups (%0d hits) and %0d inserts (%0d evictions);",
               n_lookups, n_hits, n_inserts, n_evicts);
      $display("%0d responses compared, %0d errors", n_checked, err_cnt);
      if (err_cnt == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("Timeout: cache stopped responding");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
